>>> rtl/core/csl_pkg.sv
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants of the C subset lexer
// Token kinds, the result record, the scanner output bundle and keyword codes.
// ----------------------------------------------------------------------------
package csl_pkg;

	// Longest token length that is counted before the length saturates.
	localparam int MAX_TOKEN_LEN = 255;
	localparam int LEN_CAP_INT   = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
	localparam logic [7:0] LEN_CAP = 8'(LEN_CAP_INT);

	// Result queue between the scanner and the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// Keywords packed with the first character in the lowest byte.
	localparam logic [39:0] KW_INT   = 40'h0000746E69;
	localparam logic [39:0] KW_MAIN  = 40'h006E69616D;
	localparam logic [39:0] KW_IF    = 40'h0000006669;
	localparam logic [39:0] KW_ELSE  = 40'h0065736C65;
	localparam logic [39:0] KW_WHILE = 40'h656C696877;

	typedef enum logic [4:0] {
		TK_INT    = 5'd0,
		TK_MAIN   = 5'd1,
		TK_IF     = 5'd2,
		TK_ELSE   = 5'd3,
		TK_WHILE  = 5'd4,
		TK_IDENT  = 5'd5,
		TK_LIT    = 5'd6,
		TK_EQ     = 5'd7,
		TK_GE     = 5'd8,
		TK_LE     = 5'd9,
		TK_ASSIGN = 5'd10,
		TK_GT     = 5'd11,
		TK_LT     = 5'd12,
		TK_PLUS   = 5'd13,
		TK_MINUS  = 5'd14,
		TK_LPAREN = 5'd15,
		TK_RPAREN = 5'd16,
		TK_LBRACE = 5'd17,
		TK_RBRACE = 5'd18,
		TK_SEMI   = 5'd19,
		TK_HASH   = 5'd20,
		TK_DOT    = 5'd21,
		TK_COMMA  = 5'd22,
		TK_ERROR  = 5'd23
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [7:0] length;
		logic [7:0] first;
		logic       clipped;
		logic       last;
	} tok_t;

	// What the scanner produces for the byte it is looking at.
	typedef struct packed {
		logic [1:0]     count;
		tok_t [1:0]     tok;
	} scan_out_t;

endpackage

>>> rtl/core/csl_scan.sv
// ----------------------------------------------------------------------------
// csl_scan: tokenizer state and next-token logic
// Holds the pending token and forms up to two results for the current byte.
// ----------------------------------------------------------------------------
module csl_scan (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                end_of_stream,
	output csl_pkg::scan_out_t  result
);
	import csl_pkg::*;

	typedef enum logic [3:0] {
		M_IDLE = 4'b0001,
		M_WORD = 4'b0010,
		M_NUM  = 4'b0100,
		M_REL  = 4'b1000
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [7:0]  len_q, len_d;
	logic [39:0] prefix_q, prefix_d;
	logic [7:0]  first_q, first_d;
	logic        clip_q, clip_d;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
	endfunction

	function automatic logic is_num(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
	endfunction

	function automatic logic is_rel(input logic [7:0] b);
		return b == "=" || b == ">" || b == "<";
	endfunction

	function automatic tok_kind_t single_kind(input logic [7:0] b);
		tok_kind_t k;
		case (b)
			"=":     k = TK_ASSIGN;
			">":     k = TK_GT;
			"<":     k = TK_LT;
			"+":     k = TK_PLUS;
			"-":     k = TK_MINUS;
			"(":     k = TK_LPAREN;
			")":     k = TK_RPAREN;
			"{":     k = TK_LBRACE;
			"}":     k = TK_RBRACE;
			";":     k = TK_SEMI;
			"#":     k = TK_HASH;
			".":     k = TK_DOT;
			",":     k = TK_COMMA;
			default: k = TK_ERROR;
		endcase
		return k;
	endfunction

	tok_kind_t   word_kind;
	logic        flush_v, idle_v;
	tok_t        flush_t, idle_t, pair_t;
	logic [39:0] ext_prefix;
	logic [7:0]  ext_len;
	logic        ext_clip;
	mode_t       fi_mode;
	logic [39:0] fi_prefix;
	logic [7:0]  fi_len, fi_first;
	logic [1:0]  cnt;

	// A clipped word never matches a keyword; lengths guard the prefix compare.
	always_comb begin
		word_kind = TK_IDENT;
		if (!clip_q) begin
			if (len_q == 8'd3 && prefix_q == KW_INT) word_kind = TK_INT;
			else if (len_q == 8'd4 && prefix_q == KW_MAIN) word_kind = TK_MAIN;
			else if (len_q == 8'd2 && prefix_q == KW_IF) word_kind = TK_IF;
			else if (len_q == 8'd4 && prefix_q == KW_ELSE) word_kind = TK_ELSE;
			else if (len_q == 8'd5 && prefix_q == KW_WHILE) word_kind = TK_WHILE;
		end
	end

	// Pending token as it stands, emitted when something ends it.
	always_comb begin
		flush_v = 1'b0;
		flush_t = '{kind: TK_IDENT, length: len_q, first: first_q, clipped: clip_q, last: 1'b0};
		unique case (mode_q)
			M_WORD: begin
				flush_v      = 1'b1;
				flush_t.kind = word_kind;
			end
			M_NUM: begin
				flush_v      = 1'b1;
				flush_t.kind = TK_LIT;
			end
			M_REL: begin
				flush_v         = 1'b1;
				flush_t.kind    = single_kind(first_q);
				flush_t.length  = 8'd1;
				flush_t.clipped = 1'b0;
			end
			default: flush_v = 1'b0;
		endcase
	end

	// The byte seen with nothing pending: skipped, a token start, or a token.
	always_comb begin
		idle_v    = !is_blank(in_byte) && !is_letter(in_byte) && !is_num(in_byte)
			&& !is_rel(in_byte);
		idle_t    = '{kind: single_kind(in_byte), length: 8'd1, first: in_byte,
			clipped: 1'b0, last: 1'b0};
		fi_mode   = M_IDLE;
		fi_len    = 8'd0;
		fi_prefix = '0;
		fi_first  = first_q;
		if (is_letter(in_byte)) fi_mode = M_WORD;
		else if (is_num(in_byte)) fi_mode = M_NUM;
		else if (is_rel(in_byte)) fi_mode = M_REL;
		if (fi_mode != M_IDLE) begin
			fi_len    = 8'd1;
			fi_prefix = {32'd0, in_byte};
			fi_first  = in_byte;
		end
	end

	// Growing the pending token by one byte.
	always_comb begin
		ext_prefix = prefix_q;
		for (int i = 0; i < 5; i++) begin
			if (len_q == 8'(i)) ext_prefix[8*i +: 8] = in_byte;
		end
		ext_len  = (len_q < LEN_CAP) ? len_q + 8'd1 : len_q;
		ext_clip = clip_q | (len_q >= LEN_CAP);
	end

	always_comb begin
		mode_d   = fi_mode;
		len_d    = fi_len;
		prefix_d = fi_prefix;
		first_d  = fi_first;
		clip_d   = 1'b0;
		cnt      = 2'(flush_v) + 2'(idle_v);
		pair_t   = idle_t;
		if (flush_v) pair_t = flush_t;
		if (end_of_stream) begin
			mode_d   = M_IDLE;
			len_d    = 8'd0;
			prefix_d = '0;
			first_d  = first_q;
			cnt      = 2'(flush_v);
			pair_t   = flush_t;
		end else if ((mode_q == M_WORD && (is_letter(in_byte) || is_num(in_byte)))
				|| (mode_q == M_NUM && is_num(in_byte))) begin
			mode_d   = mode_q;
			len_d    = ext_len;
			prefix_d = ext_prefix;
			first_d  = first_q;
			clip_d   = ext_clip;
			cnt      = 2'd0;
		end else if (mode_q == M_REL && in_byte == "=") begin
			mode_d        = M_IDLE;
			len_d         = 8'd0;
			prefix_d      = '0;
			first_d       = first_q;
			clip_d        = clip_q;
			cnt           = 2'd1;
			pair_t        = flush_t;
			pair_t.length = 8'd2;
			pair_t.kind   = (first_q == "=") ? TK_EQ : ((first_q == ">") ? TK_GE : TK_LE);
		end
	end

	always_comb begin
		result.count       = cnt;
		result.tok[0]      = pair_t;
		result.tok[0].last = (cnt == 2'd1);
		result.tok[1]      = idle_t;
		result.tok[1].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			len_q    <= 8'd0;
			prefix_q <= '0;
			first_q  <= 8'd0;
			clip_q   <= 1'b0;
		end else if (step) begin
			mode_q   <= mode_d;
			len_q    <= len_d;
			prefix_q <= prefix_d;
			first_q  <= first_d;
			clip_q   <= clip_d;
		end
	end

endmodule

>>> rtl/core/c_subset_lexer_core.sv
// ----------------------------------------------------------------------------
// c_subset_lexer_core: byte-serial tokenizer for a small C subset
// Registers each source byte, scans it against the pending token and queues
// up to two token records for the output stream.
// ----------------------------------------------------------------------------
// Path: each byte is registered in the input stage, then scanned into the queue.
// Throughput: one byte per cycle while the queue has room for two records; a
// byte that yields two tokens takes two transactions on the single output
// port, so sustained rate is set by the output.
// Reset: arst_n clears the scan state, the input stage and the result queue
// at once; no clearing pass is needed and the block is ready straight away.
// ----------------------------------------------------------------------------
module c_subset_lexer_core (
	input  logic        clk,
	input  logic        arst_n,
	// Source bytes; end of stream travels as s_tlast.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // end_of_stream
	// Token records; the last record caused by one byte carries m_tlast.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [4:0] token_kind, [12:5] token_length,
	                               // [20:13] token_byte, [23:21] zero
	output logic        m_tuser,   // length_clipped
	output logic        m_tlast    // last_of_run
);
	import csl_pkg::*;

	// Input stage. A byte waits here until the queue has room for the two
	// records it may cause; a new transaction is taken whenever the stage
	// is empty or empties in the same cycle.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eos_s1;
	logic       fire;

	scan_out_t  scan;

	tok_t                 fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 pop;
	tok_t                 head;

	assign fire     = valid_s1 && (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign s_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// The payload follows the valid bit and needs no reset.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eos_s1  <= s_tlast;
		end
	end

	// The scanner updates its pending token only when the byte moves on.
	csl_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (fire),
		.in_byte       (byte_s1),
		.end_of_stream (eos_s1),
		.result        (scan)
	);

	// Result queue. Up to two records are written per cycle, in order, and
	// one is read out per output transaction.
	assign pop  = m_tready && (cnt_q != '0);
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (fire && scan.count != 2'd0) begin
			fifo_q[wr_ptr_q] <= scan.tok[0];
			if (scan.count == 2'd2) fifo_q[wr_ptr_q + FIFO_AW'(1)] <= scan.tok[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (fire) wr_ptr_q <= wr_ptr_q + FIFO_AW'(scan.count);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			cnt_q <= cnt_q + (fire ? FIFO_CW'(scan.count) : '0) - FIFO_CW'(pop);
		end
	end

	assign m_tvalid = (cnt_q != '0);
	assign m_tdata  = {3'b000, head.first, head.length, 5'(head.kind)};
	assign m_tuser  = head.clipped;
	assign m_tlast  = head.last;

	// The queue never holds more records than it has entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FIFO_CW'(FIFO_DEPTH))
		else $error("result queue count beyond its depth");

	// A scan step never writes more records than the queue has free.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (32'(cnt_q) + 32'(scan.count) <= FIFO_DEPTH))
		else $error("result queue overflow");

	// A byte held back by a queue without room for two records stays in the input stage unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(byte_s1) && $stable(eos_s1))
		else $error("stalled input stage lost its byte");

	// Two records from one byte: only the second one closes the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && scan.count == 2'd2 |-> !scan.tok[0].last && scan.tok[1].last)
		else $error("wrong last marking on a record pair");

endmodule
